/* hdl/fba_pkg.sv */
// Shared types and constants for the file block allocator.
// Used by file_block_allocator; depends on nothing else.

package fba_pkg;

    // Default geometry, handed to the top level as parameter defaults
    localparam int BLOCKS_DEF    = 64;
    localparam int MAX_FILES_DEF = 256;

    // Fixed field widths
    localparam int SIZE_W   = 22;                 // size_kb
    localparam int BS_W     = 16;                 // block_size_kb
    localparam int BU_W     = 7;                  // blocks_in_use
    localparam int FID_W    = 8;                  // file_id
    localparam int FIRST_W  = 6;                  // first_block
    localparam int TAKEN_W  = 7;                  // blocks_taken
    localparam int NEED_W   = SIZE_W + 1;         // block count, index block included
    localparam int STEP_W   = $clog2(SIZE_W);     // divider step counter
    localparam int CFG_IX_W = 2;

    // Commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_WIPE  = 1'b1;

    // Allocation modes
    localparam logic [1:0] MODE_CONTIG  = 2'd0;
    localparam logic [1:0] MODE_LINKED  = 2'd1;
    localparam logic [1:0] MODE_INDEXED = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IX_W-1:0] REG_ALLOC_MODE    = 2'd0;
    localparam logic [CFG_IX_W-1:0] REG_BLOCK_SIZE_KB = 2'd1;
    localparam logic [CFG_IX_W-1:0] REG_BLOCKS_IN_USE = 2'd2;

    // Status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_NEED,
        ST_SCAN_C,
        ST_MARK,
        ST_SCAN_L,
        ST_RESULT
    } fba_state_t;

endpackage

/* hdl/fba_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; instanced by file_block_allocator for the owner table.

module fba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* hdl/file_block_allocator.sv */
// File block allocator: keeps a used/free map of disk blocks and grants blocks to files.
// Uses fba_pkg for types and constants and fba_ram for the block owner table.
//
// Channels: an input channel (in_valid / in_stall) carries cmd, file_id and size_kb; an
// output channel (out_valid / out_stall) returns status, first_block and blocks_taken,
// one result per item. A separate write port (cfg_valid / cfg_ready, cfg_index, cfg_data)
// sets alloc_mode, block_size_kb and blocks_in_use; it is always ready. The user is to write it
// only while the block is idle; the block itself does not enforce this.
// Flow: a wipe, or an allocate with a bad file id or mode, goes from the transfer to the
// result state and loads its result from there, after which the next item can be taken. An
// allocate runs a restoring divider (one quotient bit per cycle) to turn KB into blocks,
// rounds up, walks the block map one entry per cycle (a contiguous grant then passes a
// mark state) and goes to the result state, which loads the result. There is no new item
// until then: one item is in work at a time; in_stall is high from
// the transfer until the result is loaded into the output register.
// Reset clears the whole map (every block free) and sets mode 0, block size 1 and 64
// managed blocks; the owner table is left as it is. When out_stall holds the result in
// the output register, the next item may still be taken and worked on, and its result
// waits until the output register is free.

module file_block_allocator
    import fba_pkg::*;
#(
    parameter int BLOCKS    = BLOCKS_DEF,
    parameter int MAX_FILES = MAX_FILES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            cmd,
    input  logic [fba_pkg::FID_W-1:0]       file_id,
    input  logic [fba_pkg::SIZE_W-1:0]      size_kb,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            status,
    output logic [fba_pkg::FIRST_W-1:0]     first_block,
    output logic [fba_pkg::TAKEN_W-1:0]     blocks_taken,
    // configuration write port
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fba_pkg::CFG_IX_W-1:0]    cfg_index,
    input  logic [fba_pkg::BS_W-1:0]        cfg_data
);

    localparam int IDX_W = $clog2(BLOCKS);
    localparam int CNT_W = $clog2(BLOCKS + 1);

    fba_state_t              state_reg, state_next;

    logic [1:0]              mode_reg, mode_next;
    logic [BS_W-1:0]         bs_reg, bs_next;
    logic [BU_W-1:0]         bu_reg, bu_next;

    logic [BLOCKS-1:0]       map_reg, map_next;
    logic [BLOCKS-1:0]       pend_reg, pend_next;

    logic [FID_W-1:0]        fid_reg, fid_next;
    logic [SIZE_W-1:0]       quo_reg, quo_next;
    logic [BS_W-1:0]         rem_reg, rem_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [NEED_W-1:0]       need_reg, need_next;

    logic [CNT_W-1:0]        i_reg, i_next;
    logic [CNT_W-1:0]        run_reg, run_next;
    logic [CNT_W-1:0]        taken_reg, taken_next;
    logic [IDX_W-1:0]        first_reg, first_next;
    logic [IDX_W-1:0]        last_reg, last_next;

    logic                    res_status_reg, res_status_next;
    logic [FIRST_W-1:0]      res_first_reg, res_first_next;
    logic [TAKEN_W-1:0]      res_taken_reg, res_taken_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    status_reg, status_next;
    logic [FIRST_W-1:0]      first_block_reg, first_block_next;
    logic [TAKEN_W-1:0]      blocks_taken_reg, blocks_taken_next;

    // combinational helpers
    logic [CNT_W-1:0]        count;
    logic [BS_W-1:0]         bs_eff;
    logic [BS_W:0]           div_trial;
    logic                    div_bit;
    logic [IDX_W-1:0]        scan_idx;
    logic                    cur_free;
    logic [CNT_W-1:0]        run_inc;
    logic [31:0]             first_wide;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_addr;

    // managed block count, clamped to the map depth
    always_comb
    begin
        if ({{(32 - BU_W){1'b0}}, bu_reg} > 32'(BLOCKS))
        begin
            count = CNT_W'(BLOCKS);
        end
        else
        begin
            count = CNT_W'(bu_reg);
        end
    end

    assign bs_eff     = (bs_reg == '0) ? BS_W'(1) : bs_reg;
    assign div_trial  = {rem_reg, quo_reg[SIZE_W-1]};
    assign div_bit    = (div_trial >= {1'b0, bs_eff});
    assign scan_idx   = i_reg[IDX_W-1:0];
    assign cur_free   = !map_reg[scan_idx];
    assign run_inc    = cur_free ? (run_reg + CNT_W'(1)) : '0;
    assign first_wide = 32'(first_reg);
    assign ram_addr   = first_reg;

    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        bs_next           = bs_reg;
        bu_next           = bu_reg;
        map_next          = map_reg;
        pend_next         = pend_reg;
        fid_next          = fid_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        step_next         = step_reg;
        need_next         = need_reg;
        i_next            = i_reg;
        run_next          = run_reg;
        taken_next        = taken_reg;
        first_next        = first_reg;
        last_next         = last_reg;
        res_status_next   = res_status_reg;
        res_first_next    = res_first_reg;
        res_taken_next    = res_taken_reg;
        out_valid_next    = out_valid_reg;
        status_next       = status_reg;
        first_block_next  = first_block_reg;
        blocks_taken_next = blocks_taken_reg;
        ram_we            = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ALLOC_MODE:    mode_next = cfg_data[1:0];
                REG_BLOCK_SIZE_KB: bs_next   = cfg_data;
                REG_BLOCKS_IN_USE: bu_next   = cfg_data[BU_W-1:0];
                default:           ;
            endcase
        end

        // drop the held result once the receiver takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    fid_next        = file_id;
                    quo_next        = size_kb;
                    rem_next        = '0;
                    step_next       = '0;
                    res_first_next  = '0;
                    res_taken_next  = '0;
                    if (cmd == CMD_WIPE)
                    begin
                        map_next        = '0;
                        res_status_next = STATUS_OK;
                        state_next      = ST_RESULT;
                    end
                    else if ((32'(file_id) >= 32'(MAX_FILES)) || (mode_reg > MODE_INDEXED))
                    begin
                        res_status_next = STATUS_FAIL;
                        state_next      = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                // one quotient bit per cycle
                if (div_bit)
                begin
                    rem_next = BS_W'(div_trial - {1'b0, bs_eff});
                end
                else
                begin
                    rem_next = div_trial[BS_W-1:0];
                end
                quo_next  = {quo_reg[SIZE_W-2:0], div_bit};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SIZE_W - 1))
                begin
                    state_next = ST_NEED;
                end
            end

            ST_NEED:
            begin
                // round up, and add the index block in indexed mode
                need_next = NEED_W'(quo_reg) + NEED_W'(rem_reg != '0)
                          + NEED_W'(mode_reg == MODE_INDEXED);
                i_next     = '0;
                run_next   = '0;
                taken_next = '0;
                first_next = '0;
                pend_next  = '0;
                if (mode_reg == MODE_CONTIG)
                begin
                    if (need_next == '0)
                    begin
                        res_status_next = STATUS_OK;
                        state_next      = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_SCAN_C;
                    end
                end
                else
                begin
                    state_next = ST_SCAN_L;
                end
            end

            ST_SCAN_C:
            begin
                if (i_reg == count)
                begin
                    res_status_next = STATUS_FAIL;
                    state_next      = ST_RESULT;
                end
                else
                begin
                    run_next = run_inc;
                    if (NEED_W'(run_inc) == need_reg)
                    begin
                        first_next = IDX_W'(i_reg + CNT_W'(1) - need_reg[CNT_W-1:0]);
                        last_next  = scan_idx;
                        state_next = ST_MARK;
                    end
                    else
                    begin
                        i_next = i_reg + CNT_W'(1);
                    end
                end
            end

            ST_MARK:
            begin
                for (int j = 0; j < BLOCKS; j++)
                begin
                    if ((IDX_W'(j) >= first_reg) && (IDX_W'(j) <= last_reg))
                    begin
                        map_next[j] = 1'b1;
                    end
                end
                ram_we          = 1'b1;
                res_status_next = STATUS_OK;
                res_first_next  = first_wide[FIRST_W-1:0];
                res_taken_next  = need_reg[TAKEN_W-1:0];
                state_next      = ST_RESULT;
            end

            ST_SCAN_L:
            begin
                if (NEED_W'(taken_reg) == need_reg)
                begin
                    // commit the gathered blocks
                    map_next        = map_reg | pend_reg;
                    ram_we          = (taken_reg != '0);
                    res_status_next = STATUS_OK;
                    res_first_next  = first_wide[FIRST_W-1:0];
                    res_taken_next  = TAKEN_W'(taken_reg);
                    state_next      = ST_RESULT;
                end
                else if (i_reg == count)
                begin
                    res_status_next = STATUS_FAIL;
                    state_next      = ST_RESULT;
                end
                else
                begin
                    if (cur_free)
                    begin
                        pend_next[scan_idx] = 1'b1;
                        if (taken_reg == '0)
                        begin
                            first_next = scan_idx;
                        end
                        taken_next = taken_reg + CNT_W'(1);
                    end
                    i_next = i_reg + CNT_W'(1);
                end
            end

            ST_RESULT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    status_next       = res_status_reg;
                    first_block_next  = res_first_reg;
                    blocks_taken_next = res_taken_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_CONTIG;
            bs_reg        <= BS_W'(1);
            bu_reg        <= BU_W'(64);
            map_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            bs_reg        <= bs_next;
            bu_reg        <= bu_next;
            map_reg       <= map_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg         <= pend_next;
        fid_reg          <= fid_next;
        quo_reg          <= quo_next;
        rem_reg          <= rem_next;
        step_reg         <= step_next;
        need_reg         <= need_next;
        i_reg            <= i_next;
        run_reg          <= run_next;
        taken_reg        <= taken_next;
        first_reg        <= first_next;
        last_reg         <= last_next;
        res_status_reg   <= res_status_next;
        res_first_reg    <= res_first_next;
        res_taken_reg    <= res_taken_next;
        status_reg       <= status_next;
        first_block_reg  <= first_block_next;
        blocks_taken_reg <= blocks_taken_next;
    end

    // owner of each file's head or index block
    fba_ram #(
        .WIDTH (FID_W),
        .DEPTH (BLOCKS)
    ) u_owner_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_addr),
        .wr_data (fid_reg),
        .rd_addr (ram_addr),
        .rd_data ()
    );

    assign in_stall     = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign first_block  = first_block_reg;
    assign blocks_taken = blocks_taken_reg;

    // a failed allocation reports no blocks
    a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_FAIL)) |-> ((first_block == '0) && (blocks_taken == '0)))
        else $error("failed allocation reports blocks");

    // the divider remainder stays below the block size
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < bs_eff))
        else $error("divider remainder out of range");

    // the gather pass never takes more blocks than are managed
    a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_L) |-> ((taken_reg <= i_reg) && (i_reg <= count)))
        else $error("gather pass overran the managed blocks");

    // a new result is loaded only when the previous one has gone
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(first_block)))
        else $error("held result overwritten");

endmodule
